@@ design/priority_job_queue_top_defines.svh @@
// Assertion macros for the priority job queue
`ifndef PRIORITY_JOB_QUEUE_TOP_DEFINES_SVH
`define PRIORITY_JOB_QUEUE_TOP_DEFINES_SVH

// check cons in the same cycle as ante
`define PJQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// check cons in the cycle after ante
`define PJQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/pjq_pkg.sv @@
// Shared types and codes for the priority job queue
`timescale 1ns / 1ps

package pjq_pkg;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  prio;
    logic [15:0] burst;
  } job_t;

  typedef struct packed {
    status_e     status;
    job_t        job;
    logic [3:0]  occupancy;
  } result_t;

endpackage

@@ design/priority_job_queue_top.sv @@
// Top level of the priority job queue
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+---------------------------------------
//   in      | input     | in_valid_i / in_stall_o    | command, job_id, job_priority, job_burst
//   out     | output    | out_valid_o / out_stall_i  | status, out_id, out_priority,
//           |           |                            | out_burst, occupancy
//
// Insert and failed commands: result registered and offered in ST_FINISH, next accept back in ST_IDLE.
// Remove: ST_SCAN, then ST_SHIFT, then ST_FINISH before the next accept in ST_IDLE;
// one memory read per cycle for the scan, then one read and one write per cycle for the gap.
// Reset clears the job count and the control state; slot contents are not cleared.
// A stalled result holds in the output register; the next transaction is accepted
// meanwhile and waits at its end until that register frees up.
`timescale 1ns / 1ps
`include "priority_job_queue_top_defines.svh"

module priority_job_queue_top #(
  parameter int unsigned DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [15:0] job_id_i,
  input  logic [7:0]  job_priority_i,
  input  logic [15:0] job_burst_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [15:0] out_id_o,
  output logic [7:0]  out_priority_o,
  output logic [15:0] out_burst_o,
  output logic [3:0]  occupancy_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  pjq_pkg::job_t    in_job;
  pjq_pkg::result_t res;
  pjq_pkg::result_t out_res_q;
  logic             res_valid;
  logic             res_ready;
  logic             out_valid_q;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  pjq_pkg::job_t    mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  pjq_pkg::job_t    mem_rdata;

  assign in_job.id    = job_id_i;
  assign in_job.prio  = job_priority_i;
  assign in_job.burst = job_burst_i;

  pjq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_cmd_i    (command_i),
    .in_job_i    (in_job),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  pjq_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_res_q.status;
  assign out_id_o       = out_res_q.job.id;
  assign out_priority_o = out_res_q.job.prio;
  assign out_burst_o    = out_res_q.job.burst;
  assign occupancy_o    = out_res_q.occupancy;

  `PJQ_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o,
                   "accepted while busy")
  `PJQ_ASSERT_SAME(a_overflow_full,
                   out_valid_o && (status_o == pjq_pkg::STATUS_OVERFLOW),
                   occupancy_o == 4'(DEPTH), "overflow below full")
  `PJQ_ASSERT_SAME(a_underflow_empty,
                   out_valid_o && (status_o == pjq_pkg::STATUS_UNDERFLOW),
                   (occupancy_o == 4'd0) && (out_id_o == 16'd0) && (out_burst_o == 16'd0),
                   "underflow result not empty")

endmodule

@@ design/pjq_store.sv @@
// Job slot memory with one write port and one registered read port
`timescale 1ns / 1ps

module pjq_store #(
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  pjq_pkg::job_t   wdata_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  output pjq_pkg::job_t   rdata_o
);

  pjq_pkg::job_t mem [DEPTH];
  pjq_pkg::job_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/pjq_ctrl.sv @@
// Sequencer for insert and remove, with the priority compare used by the remove scan
`timescale 1ns / 1ps

module pjq_ctrl #(
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              in_cmd_i,
  input  pjq_pkg::job_t     in_job_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output pjq_pkg::result_t  res_o,
  output logic              mem_we_o,
  output logic [AW-1:0]     mem_waddr_o,
  output pjq_pkg::job_t     mem_wdata_o,
  output logic              mem_re_o,
  output logic [AW-1:0]     mem_raddr_o,
  input  pjq_pkg::job_t     mem_rdata_i
);

  pjq_pkg::state_e  state_q, state_d;
  logic [CW-1:0]    fill_q, fill_d;
  logic [AW-1:0]    cmp_idx_q, cmp_idx_d;
  logic [AW-1:0]    shift_idx_q, shift_idx_d;
  logic [AW-1:0]    best_idx_q, best_idx_d;
  pjq_pkg::job_t    best_job_q, best_job_d;
  pjq_pkg::status_e status_q, status_d;

  logic             take;
  logic [AW-1:0]    best_idx_n;
  logic [CW-1:0]    cmp_nxt;
  logic [CW-1:0]    best_nxt;
  logic [CW-1:0]    shift_nxt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pjq_pkg::ST_IDLE;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q   <= cmp_idx_d;
    shift_idx_q <= shift_idx_d;
    best_idx_q  <= best_idx_d;
    best_job_q  <= best_job_d;
    status_q    <= status_d;
  end

  assign take       = (cmp_idx_q == '0) || (mem_rdata_i.prio > best_job_q.prio);
  assign best_idx_n = take ? cmp_idx_q : best_idx_q;
  assign cmp_nxt    = CW'(cmp_idx_q) + CW'(1);
  assign best_nxt   = CW'(best_idx_n) + CW'(1);
  assign shift_nxt  = CW'(shift_idx_q) + CW'(1);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    cmp_idx_d   = cmp_idx_q;
    shift_idx_d = shift_idx_q;
    best_idx_d  = best_idx_q;
    best_job_d  = best_job_q;
    status_d    = status_q;
    in_stall_o  = 1'b1;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = fill_q[AW-1:0];
    mem_wdata_o = in_job_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;

    case (state_q)
      pjq_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (in_cmd_i == pjq_pkg::CMD_INSERT) begin
            best_job_d = '0;
            state_d    = pjq_pkg::ST_FINISH;
            if (fill_q == CW'(DEPTH)) begin
              status_d = pjq_pkg::STATUS_OVERFLOW;
            end else begin
              status_d = pjq_pkg::STATUS_OK;
              mem_we_o = 1'b1;
              fill_d   = fill_q + CW'(1);
            end
          end else if (fill_q == '0) begin
            status_d   = pjq_pkg::STATUS_UNDERFLOW;
            best_job_d = '0;
            state_d    = pjq_pkg::ST_FINISH;
          end else begin
            status_d    = pjq_pkg::STATUS_OK;
            mem_re_o    = 1'b1;
            mem_raddr_o = '0;
            cmp_idx_d   = '0;
            state_d     = pjq_pkg::ST_SCAN;
          end
        end
      end
      pjq_pkg::ST_SCAN: begin
        best_idx_d = best_idx_n;
        best_job_d = take ? mem_rdata_i : best_job_q;
        if (cmp_nxt < fill_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = cmp_nxt[AW-1:0];
          cmp_idx_d   = cmp_nxt[AW-1:0];
        end else begin
          shift_idx_d = best_idx_n;
          state_d     = pjq_pkg::ST_SHIFT;
          if (best_nxt < fill_q) begin
            mem_re_o    = 1'b1;
            mem_raddr_o = best_nxt[AW-1:0];
          end
        end
      end
      pjq_pkg::ST_SHIFT: begin
        if (shift_nxt < fill_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = shift_idx_q;
          mem_wdata_o = mem_rdata_i;
          shift_idx_d = shift_nxt[AW-1:0];
          if ((shift_nxt + CW'(1)) < fill_q) begin
            mem_re_o    = 1'b1;
            mem_raddr_o = AW'(shift_nxt + CW'(1));
          end
        end else begin
          fill_d  = fill_q - CW'(1);
          state_d = pjq_pkg::ST_FINISH;
        end
      end
      pjq_pkg::ST_FINISH: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = pjq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pjq_pkg::ST_IDLE;
      end
    endcase
  end

  assign res_o.status    = status_q;
  assign res_o.job       = best_job_q;
  assign res_o.occupancy = 4'(fill_q);

endmodule

@@ tb/sv/job_queue_checker.sv @@
// Checker that predicts and compares the results of the priority job queue
`timescale 1ns / 1ps

module job_queue_checker #(
  parameter int unsigned DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        command_i,
  input  logic [15:0] job_id_i,
  input  logic [7:0]  job_priority_i,
  input  logic [15:0] job_burst_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  status_i,
  input  logic [15:0] out_id_i,
  input  logic [7:0]  out_priority_i,
  input  logic [15:0] out_burst_i,
  input  logic [3:0]  occupancy_i,
  output int          mismatch_count_o,
  output int          pending_count_o
);

  import pjq_pkg::*;

  job_t    held_jobs[DEPTH];
  int      held_count = 0;
  result_t expected_results[$];
  int      mismatch_count = 0;
  int      pending_count = 0;

  assign mismatch_count_o = mismatch_count;
  assign pending_count_o  = pending_count;

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic result_t apply_command(logic cmd, job_t job);
    result_t res;
    int      best;
    res        = '0;
    res.status = STATUS_OK;
    if (cmd == CMD_INSERT) begin
      if (held_count >= DEPTH) begin
        res.status = STATUS_OVERFLOW;
      end else begin
        held_jobs[held_count] = job;
        held_count++;
      end
    end else if (held_count == 0) begin
      res.status = STATUS_UNDERFLOW;
    end else begin
      best = 0;
      for (int k = 1; k < held_count; k++) begin
        if (held_jobs[k].prio > held_jobs[best].prio) best = k;
      end
      res.job = held_jobs[best];
      for (int k = best; k < held_count - 1; k++) begin
        held_jobs[k] = held_jobs[k + 1];
      end
      held_count--;
    end
    res.occupancy = 4'(held_count);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t exp_res;
    job_t    in_job;
    if (!rst_ni) begin
      held_count = 0;
      expected_results.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        in_job.id    = job_id_i;
        in_job.prio  = job_priority_i;
        in_job.burst = job_burst_i;
        expected_results.push_back(apply_command(command_i, in_job));
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result transaction with no expectation waiting");
        end else begin
          exp_res = expected_results.pop_front();
          if (status_i != exp_res.status)
            report_mismatch($sformatf("status got %0d expected %0d",
                                      status_i, exp_res.status));
          if (out_id_i != exp_res.job.id)
            report_mismatch($sformatf("id got %h expected %h", out_id_i, exp_res.job.id));
          if (out_priority_i != exp_res.job.prio)
            report_mismatch($sformatf("priority got %h expected %h",
                                      out_priority_i, exp_res.job.prio));
          if (out_burst_i != exp_res.job.burst)
            report_mismatch($sformatf("burst got %h expected %h",
                                      out_burst_i, exp_res.job.burst));
          if (occupancy_i != exp_res.occupancy)
            report_mismatch($sformatf("occupancy got %0d expected %0d",
                                      occupancy_i, exp_res.occupancy));
        end
      end
    end
    pending_count = expected_results.size();
  end

endmodule

@@ tb/sv/tb_priority_job_queue_top.sv @@
// Testbench top that drives the priority job queue and gives the verdict
`timescale 1ns / 1ps

module tb_priority_job_queue_top;

  import pjq_pkg::*;

  localparam int unsigned DEPTH        = 8;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          LONG_HOLD    = 400;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          CHUNKS       = 19;
  localparam int          CHUNK_ITEMS  = 50;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        command_i;
  logic [15:0] job_id_i;
  logic [7:0]  job_priority_i;
  logic [15:0] job_burst_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  status_o;
  logic [15:0] out_id_o;
  logic [7:0]  out_priority_o;
  logic [15:0] out_burst_o;
  logic [3:0]  occupancy_o;

  int mismatch_count;
  int pending_count;
  int cycle_count = 0;
  bit no_idle = 1'b0;
  bit long_hold_req = 1'b0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  priority_job_queue_top #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .job_id_i      (job_id_i),
    .job_priority_i(job_priority_i),
    .job_burst_i   (job_burst_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .out_id_o      (out_id_o),
    .out_priority_o(out_priority_o),
    .out_burst_o   (out_burst_o),
    .occupancy_o   (occupancy_o)
  );

  job_queue_checker #(
    .DEPTH(DEPTH)
  ) checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .command_i       (command_i),
    .job_id_i        (job_id_i),
    .job_priority_i  (job_priority_i),
    .job_burst_i     (job_burst_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_i        (status_o),
    .out_id_i        (out_id_o),
    .out_priority_i  (out_priority_o),
    .out_burst_i     (out_burst_o),
    .occupancy_i     (occupancy_o),
    .mismatch_count_o(mismatch_count),
    .pending_count_o (pending_count)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic offer_job(logic cmd, logic [15:0] id, logic [7:0] prio, logic [15:0] burst);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    job_id_i       <= id;
    job_priority_i <= prio;
    job_burst_i    <= burst;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // receiver: random stall per transaction (none while no_idle), one long hold on request
  initial begin : receiver
    int gap;
    out_stall_i = 1'b1;
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        gap = LONG_HOLD;
      end else if (no_idle) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 6);
      end
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  initial begin : stimulus
    int          insert_pct;
    logic        cmd;
    logic [7:0]  prio;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    command_i      = CMD_INSERT;
    job_id_i       = '0;
    job_priority_i = '0;
    job_burst_i    = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    offer_job(CMD_REMOVE, 16'h1234, 8'h55, 16'h4321);
    offer_job(CMD_INSERT, 16'h0000, 8'h00, 16'h0000);
    offer_job(CMD_INSERT, 16'hFFFF, 8'h00, 16'hFFFF);
    offer_job(CMD_REMOVE, 16'hFFFF, 8'hFF, 16'hFFFF);
    offer_job(CMD_REMOVE, 16'h0000, 8'h00, 16'h0000);
    offer_job(CMD_REMOVE, 16'h0000, 8'h00, 16'h0000);
    offer_job(CMD_INSERT, 16'h0001, 8'd5,   16'h00FF);
    offer_job(CMD_INSERT, 16'h0002, 8'd255, 16'hFF00);
    offer_job(CMD_INSERT, 16'h0003, 8'd7,   16'h5555);
    offer_job(CMD_INSERT, 16'h0004, 8'd255, 16'hAAAA);
    offer_job(CMD_INSERT, 16'h0005, 8'd0,   16'h0001);
    offer_job(CMD_INSERT, 16'h0006, 8'd128, 16'h8000);
    offer_job(CMD_INSERT, 16'h0007, 8'd255, 16'h7FFF);
    offer_job(CMD_INSERT, 16'h0008, 8'd1,   16'hFFFE);
    offer_job(CMD_INSERT, 16'hBEEF, 8'd200, 16'h1111);
    offer_job(CMD_REMOVE, 16'h0000, 8'h00, 16'h0000);
    offer_job(CMD_REMOVE, 16'h0000, 8'h00, 16'h0000);
    offer_job(CMD_REMOVE, 16'h0000, 8'h00, 16'h0000);
    offer_job(CMD_INSERT, 16'hAAAA, 8'd255, 16'h5555);
    offer_job(CMD_REMOVE, 16'h0000, 8'h00, 16'h0000);
    offer_job(CMD_REMOVE, 16'h0000, 8'h00, 16'h0000);

    for (int chunk = 0; chunk < CHUNKS; chunk++) begin
      no_idle = (chunk % 6 == 3);
      case (chunk % 4)
        0:       insert_pct = 80;
        1:       insert_pct = 50;
        2:       insert_pct = 25;
        default: insert_pct = 60;
      endcase
      if (chunk == 7) begin
        long_hold_req = 1'b1;
        insert_pct    = 95;
      end
      for (int n = 0; n < CHUNK_ITEMS; n++) begin
        cmd  = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
        prio = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
        offer_job(cmd, 16'($urandom_range(0, 65535)), prio, 16'($urandom_range(0, 65535)));
      end
    end
    no_idle = 1'b0;

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/pjq_pkg.sv
design/pjq_store.sv
design/pjq_ctrl.sv
design/priority_job_queue_top.sv
tb/sv/job_queue_checker.sv
tb/sv/tb_priority_job_queue_top.sv
